// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the byte ring buffer.
// Define ASSERT_OFF to drop every check; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property at each rising edge, skipped while reset is asserted.
`define ASSERT_CLK(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (prop)) else $error(msg);

// Check a property at each rising edge, reset included.
`define ASSERT_ALWAYS(lbl, ck, prop, msg) \
    lbl: assert property (@(posedge ck) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, ck, rn, prop, msg)
`define ASSERT_ALWAYS(lbl, ck, prop, msg)

`endif

`endif

// ===== hw/rtl/brbo_pkg.sv =====
// Shared types, operation codes and constants for the byte ring buffer.
// No dependencies; used by every module of the block.
`default_nettype none

package brbo_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int CAP_W         = 9;
    localparam int CNT_W         = 16;

    typedef logic [7:0]       data_t;
    typedef logic [CAP_W-1:0] cap_t;
    typedef logic [CNT_W-1:0] count_t;
    typedef logic [2:0]       func_t;

    localparam cap_t   CAP_RESET = cap_t'(256);
    localparam count_t CNT_MAX   = '1;

    localparam func_t FUNC_PUT    = 3'd0;
    localparam func_t FUNC_FORCE  = 3'd1;
    localparam func_t FUNC_GET    = 3'd2;
    localparam func_t FUNC_PEEK   = 3'd3;
    localparam func_t FUNC_CLEAR  = 3'd4;

    // Status of one result; the byte itself comes from the storage read port.
    typedef struct packed {
        logic   ok;
        logic   rd;
        cap_t   fill_level;
        logic   is_full_now;
        count_t burst_count;
    } rslt_t;

endpackage

`default_nettype wire

// ===== hw/rtl/byte_ring_buffer_overwrite.sv =====
// Top level of the byte ring buffer with overwrite: control plus byte storage.
// Depends on brbo_pkg, brbo_ctrl and brbo_ram.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------
//   cfg     | cfg_we               | cfg_wdata (capacity)
//   in      | in_valid / in_stall  | func, data_in, burst_last
//   out     | out_valid / out_stall| ok, data_out, fill_level, is_full_now,
//           |                      | burst_count
//
// One transaction per cycle while the output is not stalled; a result appears the cycle after
// its input is taken, together with the registered read of the byte storage.
// Reset empties the buffer and sets the capacity to 256; storage is not cleared.
// A stall on the output holds the result and stalls the input in the same cycle.
// A capacity write empties the buffer.
`default_nettype none

module byte_ring_buffer_overwrite #(
    parameter int DEPTH = brbo_pkg::DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire brbo_pkg::cap_t    cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire brbo_pkg::func_t   func,
    input  wire brbo_pkg::data_t   data_in,
    input  wire logic              burst_last,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   ok,
    output brbo_pkg::data_t        data_out,
    output brbo_pkg::cap_t         fill_level,
    output logic                   is_full_now,
    output brbo_pkg::count_t       burst_count
);

    localparam int ADDR_W = $clog2(DEPTH);

    brbo_pkg::rslt_t   rslt;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    brbo_pkg::data_t   mem_wdata, mem_rdata;

    brbo_ctrl #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .data_in    (data_in),
        .burst_last (burst_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .rslt       (rslt),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr)
    );

    brbo_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign ok          = rslt.ok;
    assign data_out    = rslt.rd ? mem_rdata : '0;
    assign fill_level  = rslt.fill_level;
    assign is_full_now = rslt.is_full_now;
    assign burst_count = rslt.burst_count;

endmodule

`default_nettype wire

// ===== hw/rtl/brbo_ram.sv =====
// Byte storage of the ring buffer: one write port, one read port, registered read.
// Depends on brbo_pkg for the byte type.
`default_nettype none

module brbo_ram #(
    parameter int DEPTH  = brbo_pkg::DEPTH_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [ADDR_W-1:0]     waddr,
    input  wire brbo_pkg::data_t       wdata,
    input  wire logic                  re,
    input  wire logic [ADDR_W-1:0]     raddr,
    output brbo_pkg::data_t            rdata
);

    brbo_pkg::data_t mem [DEPTH];
    brbo_pkg::data_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold the last read byte until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/brbo_ctrl.sv =====
// Pointer, full flag and burst counter control of the byte ring buffer.
// Issues storage accesses and registers the status of each result. Uses brbo_pkg.
`default_nettype none
`include "assert_macros.svh"

module brbo_ctrl #(
    parameter int DEPTH  = brbo_pkg::DEPTH_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire brbo_pkg::cap_t        cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire brbo_pkg::func_t       func,
    input  wire brbo_pkg::data_t       data_in,
    input  wire logic                  burst_last,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output brbo_pkg::rslt_t            rslt,
    output logic                       mem_we,
    output logic [ADDR_W-1:0]          mem_waddr,
    output brbo_pkg::data_t            mem_wdata,
    output logic                       mem_re,
    output logic [ADDR_W-1:0]          mem_raddr
);

    // Arithmetic width: holds a pointer plus one and any capacity.
    localparam int LW = (ADDR_W + 1 > brbo_pkg::CAP_W) ? ADDR_W + 1 : brbo_pkg::CAP_W;

    brbo_pkg::cap_t    cap_reg, cap_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [ADDR_W-1:0] rp_reg, rp_next;
    logic              full_reg, full_next;
    brbo_pkg::count_t  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    brbo_pkg::rslt_t   rslt_reg, rslt_next;

    logic [LW-1:0]     eff_cap;
    logic              acc;
    logic              empty;
    logic [ADDR_W-1:0] wp_adv, rp_adv, rp_mid;
    logic [ADDR_W-1:0] wp_new, rp_new;
    logic              full_new;
    logic              ok, counts;
    logic [LW-1:0]     wp_x, rp_x, lvl;
    brbo_pkg::count_t  cnt_res;

    function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] p,
                                                  input logic [LW-1:0] cap);
        logic [LW-1:0] n;
        n = LW'(p) + LW'(1);
        return (n >= cap) ? '0 : n[ADDR_W-1:0];
    endfunction

    // Capacity of zero acts as one, above the storage depth as the depth.
    always_comb
    begin
        priority if (cap_reg == '0)
        begin
            eff_cap = LW'(1);
        end
        else if (32'(cap_reg) > DEPTH)
        begin
            eff_cap = LW'(DEPTH);
        end
        else
        begin
            eff_cap = LW'(cap_reg);
        end
    end

    assign in_stall = out_valid_reg & out_stall;
    assign acc      = in_valid & ~in_stall;
    assign empty    = ~full_reg & (wp_reg == rp_reg);
    assign wp_adv   = advance(wp_reg, eff_cap);
    assign rp_adv   = advance(rp_reg, eff_cap);
    // Drop the oldest byte first on a forced put into a full buffer.
    assign rp_mid   = full_reg ? rp_adv : rp_reg;

    always_comb
    begin
        wp_new    = wp_reg;
        rp_new    = rp_reg;
        full_new  = full_reg;
        ok        = 1'b0;
        counts    = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        unique case (func)
            brbo_pkg::FUNC_PUT:
            begin
                counts = 1'b1;
                if (!full_reg)
                begin
                    mem_we   = acc;
                    wp_new   = wp_adv;
                    full_new = (wp_adv == rp_reg);
                    ok       = 1'b1;
                end
            end
            brbo_pkg::FUNC_FORCE:
            begin
                counts   = 1'b1;
                mem_we   = acc;
                rp_new   = rp_mid;
                wp_new   = wp_adv;
                full_new = (wp_adv == rp_mid);
                ok       = 1'b1;
            end
            brbo_pkg::FUNC_GET:
            begin
                counts = 1'b1;
                if (!empty)
                begin
                    mem_re   = acc;
                    rp_new   = rp_adv;
                    full_new = 1'b0;
                    ok       = 1'b1;
                end
            end
            brbo_pkg::FUNC_PEEK:
            begin
                if (!empty)
                begin
                    mem_re = acc;
                    ok     = 1'b1;
                end
            end
            brbo_pkg::FUNC_CLEAR:
            begin
                wp_new   = '0;
                rp_new   = '0;
                full_new = 1'b0;
                ok       = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    assign mem_waddr = wp_reg;
    assign mem_wdata = data_in;
    assign mem_raddr = rp_reg;

    assign wp_x = LW'(wp_new);
    assign rp_x = LW'(rp_new);

    always_comb
    begin
        priority if (full_new)
        begin
            lvl = eff_cap;
        end
        else if (wp_x >= rp_x)
        begin
            lvl = wp_x - rp_x;
        end
        else
        begin
            lvl = eff_cap - (rp_x - wp_x);
        end
    end

    assign cnt_res = (counts && ok && cnt_reg != brbo_pkg::CNT_MAX) ?
                     cnt_reg + brbo_pkg::count_t'(1) : cnt_reg;

    always_comb
    begin
        cap_next       = cap_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        full_next      = full_reg;
        cnt_next       = cnt_reg;
        rslt_next      = rslt_reg;
        out_valid_next = out_valid_reg & out_stall;
        if (cfg_we)
        begin
            // A capacity write also empties the buffer.
            cap_next  = cfg_wdata;
            wp_next   = '0;
            rp_next   = '0;
            full_next = 1'b0;
        end
        else if (acc)
        begin
            wp_next   = wp_new;
            rp_next   = rp_new;
            full_next = full_new;
        end
        if (acc)
        begin
            cnt_next                 = burst_last ? '0 : cnt_res;
            out_valid_next           = 1'b1;
            rslt_next.ok             = ok;
            rslt_next.rd             = mem_re;
            rslt_next.fill_level     = brbo_pkg::cap_t'(lvl);
            rslt_next.is_full_now    = full_new;
            rslt_next.burst_count    = cnt_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= brbo_pkg::CAP_RESET;
            wp_reg        <= '0;
            rp_reg        <= '0;
            full_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            full_reg      <= full_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rslt_reg <= rslt_next;
    end

    assign out_valid = out_valid_reg;
    assign rslt      = rslt_reg;

    `ASSERT_CLK(a_full_ptr_eq, clk, rst_n, full_reg |-> (wp_reg == rp_reg), "full with unequal pointers")
    `ASSERT_CLK(a_ptr_in_cap, clk, rst_n, (LW'(wp_reg) < eff_cap) && (LW'(rp_reg) < eff_cap), "pointer at or beyond capacity")
    `ASSERT_ALWAYS(a_one_port, clk, !(mem_we && mem_re), "storage read and write in one transaction")
    `ASSERT_CLK(a_clear, clk, rst_n, (acc && !cfg_we && func == brbo_pkg::FUNC_CLEAR) |=> (wp_reg == '0 && rp_reg == '0 && !full_reg), "clear left data behind")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench for byte_ring_buffer_overwrite: directed table, then randomised op bursts.
// Needs brbo_pkg and block RTL; results checked against table rows or an inline ring model.

module tb;

    localparam brbo_pkg::func_t FUNC_SPARE_LO = 3'd5;
    localparam brbo_pkg::func_t FUNC_SPARE_HI = 3'd7;
    localparam int              HOLD_CYCLES   = 200;
    localparam int              QUIET_LIMIT   = 2000;
    localparam int              PRINT_LIMIT   = 40;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
    typedef enum logic {ROW_OP, ROW_CAP} row_kind_t;

    typedef struct packed {
        logic             ok;
        brbo_pkg::data_t  data;
        brbo_pkg::cap_t   fill;
        logic             full;
        brbo_pkg::count_t count;
    } reply_t;

    typedef struct {
        row_kind_t       kind;
        brbo_pkg::func_t f;
        brbo_pkg::data_t d;
        logic            last;
        logic            typed;
        reply_t          want;
        brbo_pkg::cap_t  cap;
    } row_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_we      = 1'b0;
    brbo_pkg::cap_t   cfg_wdata   = '0;
    logic             in_valid    = 1'b0;
    logic             in_stall;
    brbo_pkg::func_t  func        = brbo_pkg::FUNC_PUT;
    brbo_pkg::data_t  data_in     = '0;
    logic             burst_last  = 1'b0;
    logic             out_valid;
    logic             out_stall   = 1'b0;
    logic             ok;
    brbo_pkg::data_t  data_out;
    brbo_pkg::cap_t   fill_level;
    logic             is_full_now;
    brbo_pkg::count_t burst_count;

    // Ring model state
    brbo_pkg::data_t  ring_mem [brbo_pkg::DEPTH_DEFAULT];
    brbo_pkg::cap_t   ring_wr;
    brbo_pkg::cap_t   ring_rd;
    logic             ring_full;
    brbo_pkg::count_t ring_burst;
    brbo_pkg::cap_t   ring_cap;

    reply_t ring_replies [$];
    row_t   plan [$];

    int mismatches     = 0;
    int ring_ops       = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_taken     = 0;
    int quiet_cycles   = 0;

    byte_ring_buffer_overwrite u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .data_in     (data_in),
        .burst_last  (burst_last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ok          (ok),
        .data_out    (data_out),
        .fill_level  (fill_level),
        .is_full_now (is_full_now),
        .burst_count (burst_count)
    );

    always #4 clk = ~clk;

    function automatic brbo_pkg::cap_t ring_eff_cap();
        if (ring_cap == 9'd0)
            return 9'd1;
        if (ring_cap > brbo_pkg::cap_t'(brbo_pkg::DEPTH_DEFAULT))
            return brbo_pkg::cap_t'(brbo_pkg::DEPTH_DEFAULT);
        return ring_cap;
    endfunction

    function automatic brbo_pkg::cap_t ring_next(input brbo_pkg::cap_t p);
        brbo_pkg::cap_t n;
        n = p + 9'd1;
        return (n >= ring_eff_cap()) ? 9'd0 : n;
    endfunction

    function automatic void ring_store(input brbo_pkg::data_t d);
        ring_mem[ring_wr[7:0]] = d;
        ring_wr = ring_next(ring_wr);
        if (ring_wr == ring_rd)
            ring_full = 1'b1;
    endfunction

    function automatic void ring_empty();
        ring_wr   = '0;
        ring_rd   = '0;
        ring_full = 1'b0;
    endfunction

    // Apply one op to the model and return the reply it should produce
    function automatic reply_t ring_step(input brbo_pkg::func_t f, input brbo_pkg::data_t d,
                                         input logic last);
        reply_t         r;
        logic           counts;
        logic           was_empty;
        brbo_pkg::cap_t lv;
        r         = '0;
        counts    = 1'b0;
        was_empty = !ring_full && (ring_wr == ring_rd);
        case (f)
            brbo_pkg::FUNC_PUT:
            begin
                if (!ring_full)
                begin
                    ring_store(d);
                    r.ok = 1'b1;
                end
                counts = 1'b1;
            end
            brbo_pkg::FUNC_FORCE:
            begin
                // drop the oldest byte first
                if (ring_full)
                    ring_rd = ring_next(ring_rd);
                ring_store(d);
                r.ok   = 1'b1;
                counts = 1'b1;
            end
            brbo_pkg::FUNC_GET:
            begin
                if (!was_empty)
                begin
                    r.data    = ring_mem[ring_rd[7:0]];
                    ring_rd   = ring_next(ring_rd);
                    ring_full = 1'b0;
                    r.ok      = 1'b1;
                end
                counts = 1'b1;
            end
            brbo_pkg::FUNC_PEEK:
            begin
                if (!was_empty)
                begin
                    r.data = ring_mem[ring_rd[7:0]];
                    r.ok   = 1'b1;
                end
            end
            brbo_pkg::FUNC_CLEAR:
            begin
                ring_empty();
                r.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (counts && r.ok && ring_burst != brbo_pkg::CNT_MAX)
            ring_burst = ring_burst + 16'd1;
        if (ring_full)
            lv = ring_eff_cap();
        else if (ring_wr >= ring_rd)
            lv = ring_wr - ring_rd;
        else
            lv = ring_eff_cap() - (ring_rd - ring_wr);
        r.fill  = lv;
        r.full  = (lv == ring_eff_cap());
        r.count = ring_burst;
        if (last)
            ring_burst = '0;
        return r;
    endfunction

    function automatic row_t row_typed(input brbo_pkg::func_t f, input brbo_pkg::data_t d,
                                       input logic last, input logic rok,
                                       input brbo_pkg::data_t rdata,
                                       input brbo_pkg::cap_t rfill, input logic rfull,
                                       input brbo_pkg::count_t rcount);
        row_t w;
        w.kind  = ROW_OP;
        w.f     = f;
        w.d     = d;
        w.last  = last;
        w.typed = 1'b1;
        w.want  = {rok, rdata, rfill, rfull, rcount};
        w.cap   = '0;
        return w;
    endfunction

    function automatic row_t row_pred(input brbo_pkg::func_t f, input brbo_pkg::data_t d,
                                      input logic last);
        row_t w;
        w       = row_typed(f, d, last, 1'b0, 8'h00, 9'd0, 1'b0, 16'd0);
        w.typed = 1'b0;
        return w;
    endfunction

    function automatic row_t row_cap(input brbo_pkg::cap_t v);
        row_t w;
        w      = row_pred(brbo_pkg::FUNC_PUT, 8'h00, 1'b0);
        w.kind = ROW_CAP;
        w.cap  = v;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input reply_t want, input reply_t got);
        if (mismatches < PRINT_LIMIT)
            $display("%0t %s: got ok=%0b data=%02h fill=%0d full=%0b count=%0d, %s",
                     $realtime, what, got.ok, got.data, got.fill, got.full, got.count,
                     $sformatf("want ok=%0b data=%02h fill=%0d full=%0b count=%0d",
                               want.ok, want.data, want.fill, want.full, want.count));
        mismatches++;
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default:   begin send_idle_pct = 10; recv_stall_pct = 10; end
        endcase
    endtask

    // Called at a falling edge; returns at a falling edge after the transaction
    task automatic offer_op(input brbo_pkg::func_t f, input brbo_pkg::data_t d,
                            input logic last, input logic typed, input reply_t want);
        reply_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid   <= 1'b0;
            func       <= brbo_pkg::func_t'($urandom);
            data_in    <= brbo_pkg::data_t'($urandom);
            burst_last <= 1'($urandom);
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        data_in    <= d;
        burst_last <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = ring_step(f, d, last);
        ring_replies.push_back(typed ? want : r);
        if (f <= brbo_pkg::FUNC_CLEAR)
            ring_ops++;
        @(negedge clk);
    endtask

    // Hold the sender until every reply is back, then let the pipeline settle
    task automatic drain_replies();
        in_valid <= 1'b0;
        @(negedge clk);
        while (ring_replies.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_capacity(input brbo_pkg::cap_t v);
        drain_replies();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        ring_cap  = v;
        ring_empty();
        @(negedge clk);
    endtask

    task automatic offer_sequence();
        int lim;
        int len;
        int kind;
        lim  = (ring_eff_cap() < 9'd24) ? int'(ring_eff_cap()) : 24;
        len  = $urandom_range(lim + 2, 1);
        kind = $urandom_range(9);
        case (kind)
            0, 1, 2, 3:
                for (int i = 0; i < len; i++)
                    offer_op(($urandom_range(3) == 0) ? brbo_pkg::FUNC_FORCE
                                                      : brbo_pkg::FUNC_PUT,
                             brbo_pkg::data_t'($urandom), 1'(i == len - 1), 1'b0, '0);
            4, 5, 6:
                for (int i = 0; i < len; i++)
                    offer_op(($urandom_range(4) == 0) ? brbo_pkg::FUNC_PEEK
                                                      : brbo_pkg::FUNC_GET,
                             brbo_pkg::data_t'($urandom), 1'(i == len - 1), 1'b0, '0);
            7:
                offer_op(brbo_pkg::func_t'($urandom_range(7)), brbo_pkg::data_t'($urandom),
                         1'($urandom_range(1)), 1'b0, '0);
            8:
                offer_op(brbo_pkg::FUNC_CLEAR, brbo_pkg::data_t'($urandom),
                         1'($urandom_range(1)), 1'b0, '0);
            default:
                // broken burst: mixed ops, burst end only now and then
                for (int i = 0; i < len; i++)
                    offer_op(brbo_pkg::func_t'($urandom_range(4)), brbo_pkg::data_t'($urandom),
                             1'($urandom_range(7) == 0), 1'b0, '0);
        endcase
    endtask

    task automatic run_phase(input brbo_pkg::cap_t cap, input idle_mode_t mode, input int n,
                             input logic hold);
        int start;
        write_capacity(cap);
        set_idle(mode);
        if (hold)
            hold_asked++;
        start = ring_ops;
        while (ring_ops - start < n)
        begin
            if ($urandom_range(24) == 0)
                drain_replies();
            offer_sequence();
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_asked != hold_taken)
            begin
                hold_taken = hold_asked;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= 1'($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        reply_t seen;
        reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = {ok, data_out, fill_level, is_full_now, burst_count};
            if (ring_replies.size() == 0)
                report_mismatch("result with nothing outstanding", '0, seen);
            else
            begin
                want = ring_replies.pop_front();
                if (seen !== want)
                    report_mismatch("result mismatch", want, seen);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        foreach (ring_mem[i])
            ring_mem[i] = '0;
        ring_cap   = brbo_pkg::CAP_RESET;
        ring_burst = '0;
        ring_empty();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_idle(IDLE_NONE);

        // after reset: empty reads and spare codes, then puts, reads, clear and force
        plan.push_back(row_typed(brbo_pkg::FUNC_GET, 8'h00, 1'b0,
                                 1'b0, 8'h00, 9'd0, 1'b0, 16'd0));
        plan.push_back(row_typed(brbo_pkg::FUNC_PEEK, 8'h00, 1'b0,
                                 1'b0, 8'h00, 9'd0, 1'b0, 16'd0));
        plan.push_back(row_typed(FUNC_SPARE_LO, 8'h5A, 1'b1,
                                 1'b0, 8'h00, 9'd0, 1'b0, 16'd0));
        plan.push_back(row_typed(FUNC_SPARE_HI, 8'hFF, 1'b0,
                                 1'b0, 8'h00, 9'd0, 1'b0, 16'd0));
        plan.push_back(row_typed(brbo_pkg::FUNC_PUT, 8'h00, 1'b0,
                                 1'b1, 8'h00, 9'd1, 1'b0, 16'd1));
        plan.push_back(row_typed(brbo_pkg::FUNC_PUT, 8'hFF, 1'b0,
                                 1'b1, 8'h00, 9'd2, 1'b0, 16'd2));
        plan.push_back(row_typed(brbo_pkg::FUNC_PEEK, 8'h00, 1'b0,
                                 1'b1, 8'h00, 9'd2, 1'b0, 16'd2));
        plan.push_back(row_typed(brbo_pkg::FUNC_GET, 8'h00, 1'b1,
                                 1'b1, 8'h00, 9'd1, 1'b0, 16'd3));
        plan.push_back(row_typed(brbo_pkg::FUNC_GET, 8'h00, 1'b0,
                                 1'b1, 8'hFF, 9'd0, 1'b0, 16'd1));
        plan.push_back(row_typed(brbo_pkg::FUNC_CLEAR, 8'h00, 1'b1,
                                 1'b1, 8'h00, 9'd0, 1'b0, 16'd1));
        plan.push_back(row_typed(brbo_pkg::FUNC_FORCE, 8'hA5, 1'b1,
                                 1'b1, 8'h00, 9'd1, 1'b0, 16'd1));
        // capacity zero acts as one: full after a single byte
        plan.push_back(row_cap(9'd0));
        plan.push_back(row_typed(brbo_pkg::FUNC_PUT, 8'h11, 1'b0,
                                 1'b1, 8'h00, 9'd1, 1'b1, 16'd1));
        plan.push_back(row_typed(brbo_pkg::FUNC_PUT, 8'h22, 1'b0,
                                 1'b0, 8'h00, 9'd1, 1'b1, 16'd1));
        plan.push_back(row_typed(brbo_pkg::FUNC_PEEK, 8'h00, 1'b0,
                                 1'b1, 8'h11, 9'd1, 1'b1, 16'd1));
        plan.push_back(row_typed(brbo_pkg::FUNC_FORCE, 8'h33, 1'b0,
                                 1'b1, 8'h00, 9'd1, 1'b1, 16'd2));
        plan.push_back(row_typed(brbo_pkg::FUNC_GET, 8'h00, 1'b1,
                                 1'b1, 8'h33, 9'd0, 1'b0, 16'd3));
        plan.push_back(row_cap(9'd511));
        plan.push_back(row_pred(brbo_pkg::FUNC_FORCE, 8'h5A, 1'b1));
        plan.push_back(row_cap(9'd2));
        plan.push_back(row_pred(brbo_pkg::FUNC_PUT,   8'h01, 1'b0));
        plan.push_back(row_pred(brbo_pkg::FUNC_PUT,   8'h02, 1'b0));
        plan.push_back(row_pred(brbo_pkg::FUNC_PUT,   8'h04, 1'b0));
        plan.push_back(row_pred(brbo_pkg::FUNC_FORCE, 8'h03, 1'b0));
        plan.push_back(row_pred(brbo_pkg::FUNC_GET,   8'h00, 1'b0));
        plan.push_back(row_pred(brbo_pkg::FUNC_GET,   8'h00, 1'b0));
        plan.push_back(row_pred(brbo_pkg::FUNC_GET,   8'h00, 1'b1));
        plan.push_back(row_pred(brbo_pkg::FUNC_PUT,   8'h77, 1'b0));
        // capacity write empties the buffer
        plan.push_back(row_cap(9'd257));
        plan.push_back(row_pred(brbo_pkg::FUNC_GET,   8'h00, 1'b1));
        plan.push_back(row_pred(brbo_pkg::FUNC_PEEK,  8'h00, 1'b1));

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CAP)
                write_capacity(plan[i].cap);
            else
                offer_op(plan[i].f, plan[i].d, plan[i].last, plan[i].typed, plan[i].want);
        end

        // fill the full depth and keep overwriting past the wrap
        write_capacity(brbo_pkg::CAP_RESET);
        set_idle(IDLE_NONE);
        repeat (brbo_pkg::DEPTH_DEFAULT + 8)
            offer_op(brbo_pkg::FUNC_FORCE, brbo_pkg::data_t'($urandom), 1'b0, 1'b0, '0);
        offer_op(brbo_pkg::FUNC_GET, brbo_pkg::data_t'($urandom), 1'b1, 1'b0, '0);

        run_phase(9'd3,                IDLE_NONE, 200, 1'b1);
        run_phase(9'd1,                IDLE_SEND, 150, 1'b0);
        run_phase(9'd0,                IDLE_RECV, 150, 1'b0);
        run_phase(9'd16,               IDLE_BOTH, 200, 1'b0);
        run_phase(brbo_pkg::CAP_RESET, IDLE_RECV, 200, 1'b1);
        run_phase(9'd2,                IDLE_BOTH, 150, 1'b0);
        run_phase(9'd511,              IDLE_NONE, 150, 1'b0);
        run_phase(brbo_pkg::cap_t'($urandom_range(40, 3)), IDLE_SEND, 125, 1'b0);
        run_phase(9'd257,              IDLE_BOTH, 125, 1'b0);

        drain_replies();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && ring_replies.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/brbo_pkg.sv
hw/rtl/brbo_ram.sv
hw/rtl/brbo_ctrl.sv
hw/rtl/byte_ring_buffer_overwrite.sv
verif/tb.sv
